/* sv/avr_opcode_classifier_defines.svh */
// Assertion macros used by the checker file.
`ifndef AVR_OPCODE_CLASSIFIER_DEFINES_SVH
`define AVR_OPCODE_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, held off during reset
`define AOC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("avr_opcode_classifier check failed");

// Next-cycle implication, held off during reset
`define AOC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("avr_opcode_classifier check failed");

`endif

/* sv/aoc_pkg.sv */
package aoc_pkg;

  localparam int OPC_COUNT     = 91;
  localparam int WORD_W        = 16;
  localparam int IDX_W         = 7;
  localparam int CYC_W         = 3;
  localparam int LEN_W         = 2;
  localparam logic [IDX_W-1:0] OPC_UNDEFINED = 7'd91;

  // Priority encode is split into groups of eight entries
  localparam int GRP_SIZE  = 8;
  localparam int GRP_IDX_W = 3;
  localparam int GRP_COUNT = (OPC_COUNT + GRP_SIZE - 1) / GRP_SIZE;
  localparam int MATCH_W   = GRP_COUNT * GRP_SIZE;

  localparam logic [WORD_W-1:0] OPC_CODE [OPC_COUNT] = '{
    16'h1c00, 16'h0c00, 16'h9600, 16'h2000, 16'h7000, 16'h9405, 16'h9488, 16'hf800,
    16'hf400, 16'hf000, 16'h9598, 16'h9408, 16'hfa00, 16'h940e, 16'h9800, 16'h9400,
    16'h1400, 16'h0400, 16'h3000, 16'h1000, 16'h940a, 16'h9519, 16'h9419, 16'h95d8,
    16'h9006, 16'h9007, 16'h2400, 16'h0308, 16'h0380, 16'h0388, 16'h9509, 16'h9409,
    16'hb000, 16'h9403, 16'h940c, 16'h900c, 16'h900d, 16'h900e, 16'h9009, 16'h900a,
    16'h8008, 16'h9001, 16'h9002, 16'h8000, 16'he000, 16'h9000, 16'h95c8, 16'h9004,
    16'h9005, 16'h9406, 16'h2c00, 16'h0100, 16'h9c00, 16'h0200, 16'h0300, 16'h9401,
    16'h0000, 16'h2800, 16'h6000, 16'hb800, 16'h900f, 16'h920f, 16'hd000, 16'h9508,
    16'h9518, 16'hc000, 16'h9407, 16'h0800, 16'h4000, 16'h9a00, 16'h9900, 16'h9b00,
    16'h9700, 16'hfc00, 16'hfe00, 16'h9588, 16'h95e8, 16'h920c, 16'h920d, 16'h920e,
    16'h9209, 16'h920a, 16'h8208, 16'h9201, 16'h9202, 16'h8200, 16'h9200, 16'h1800,
    16'h5000, 16'h9402, 16'h95a8
  };

  localparam logic [WORD_W-1:0] OPC_SEL [OPC_COUNT] = '{
    16'hfc00, 16'hfc00, 16'hff00, 16'hfc00, 16'hf000, 16'hfe0f, 16'hff8f, 16'hfe08,
    16'hfc00, 16'hfc00, 16'hffff, 16'hff8f, 16'hfe08, 16'hfe0e, 16'hff00, 16'hfe0f,
    16'hfc00, 16'hfc00, 16'hf000, 16'hfc00, 16'hfe0f, 16'hffff, 16'hffff, 16'hffff,
    16'hfe0f, 16'hfe0f, 16'hfc00, 16'hff88, 16'hff88, 16'hff88, 16'hffff, 16'hffff,
    16'hf800, 16'hfe0f, 16'hfe0e, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f, 16'hfe0f,
    16'hd208, 16'hfe0f, 16'hfe0f, 16'hd208, 16'hf000, 16'hfe0f, 16'hffff, 16'hfe0f,
    16'hfe0f, 16'hfe0f, 16'hfc00, 16'hff00, 16'hfc00, 16'hff00, 16'hff88, 16'hfe0f,
    16'hffff, 16'hfc00, 16'hf000, 16'hf800, 16'hfe0f, 16'hfe0f, 16'hf000, 16'hffff,
    16'hffff, 16'hf000, 16'hfe0f, 16'hfc00, 16'hf000, 16'hff00, 16'hff00, 16'hff00,
    16'hff00, 16'hfe08, 16'hfe08, 16'hffff, 16'hffff, 16'hfe0f, 16'hfe0f, 16'hfe0f,
    16'hfe0f, 16'hfe0f, 16'hd208, 16'hfe0f, 16'hfe0f, 16'hd208, 16'hfe0f, 16'hfc00,
    16'hf000, 16'hfe0f, 16'hffff
  };

  localparam logic [CYC_W-1:0] OPC_CYC [OPC_COUNT] = '{
    3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd4, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd4, 3'd2, 3'd3, 3'd3, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd2, 3'd3, 3'd2, 3'd1, 3'd1, 3'd3, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4,
    3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd1
  };

  localparam logic [LEN_W-1:0] OPC_LEN [OPC_COUNT] = '{
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
    2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd1, 2'd1, 2'd1
  };

  // Per-group winner: hit flag, local position, and table numbers
  typedef struct packed {
    logic [GRP_COUNT-1:0]                hit;
    logic [GRP_COUNT-1:0][GRP_IDX_W-1:0] lidx;
    logic [GRP_COUNT-1:0][CYC_W-1:0]     cyc;
    logic [GRP_COUNT-1:0][LEN_W-1:0]     len;
  } grp_sum_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             defined;
    logic [CYC_W-1:0] cyc;
    logic [LEN_W-1:0] len;
  } cls_res_t;

  // Compare one word against every entry; padding bits stay clear
  function automatic logic [MATCH_W-1:0] opc_match(input logic [WORD_W-1:0] word);
    logic [MATCH_W-1:0] m;
    m = '0;
    for (int i = 0; i < OPC_COUNT; i++) begin
      m[i] = ((word & OPC_SEL[i]) == OPC_CODE[i]);
    end
    return m;
  endfunction

endpackage

/* sv/aoc_match.sv */
module aoc_match (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [aoc_pkg::WORD_W-1:0]   in_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [aoc_pkg::MATCH_W-1:0]  out_match
);

  logic                        word_valid;
  logic [aoc_pkg::WORD_W-1:0]  word;
  logic                        word_ready;
  logic                        in_ready_b;
  logic [aoc_pkg::MATCH_W-1:0] match_next;

  assign word_ready = !word_valid || in_ready_b;
  assign in_ready   = word_ready;

  assign in_ready_b = !out_valid || out_ready;

  // Input register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (word_ready) begin
      word_valid <= in_valid;
    end
    if (word_ready && in_valid) begin
      word <= in_word;
    end
  end

  // Full compare against all entries
  always_comb begin
    match_next = aoc_pkg::opc_match(word);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready_b) begin
      out_valid <= word_valid;
    end
    if (in_ready_b && word_valid) begin
      out_match <= match_next;
    end
  end

endmodule

/* sv/aoc_prio.sv */
module aoc_prio (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [aoc_pkg::MATCH_W-1:0]  in_match,
  output logic                         out_valid,
  input  logic                         out_ready,
  output aoc_pkg::grp_sum_t            out_sum
);

  aoc_pkg::grp_sum_t sum_next;

  assign in_ready = !out_valid || out_ready;

  // Highest match inside each group of eight, with its table numbers
  always_comb begin
    sum_next = '0;
    for (int g = 0; g < aoc_pkg::GRP_COUNT; g++) begin
      for (int j = 0; j < aoc_pkg::GRP_SIZE; j++) begin
        if (g * aoc_pkg::GRP_SIZE + j < aoc_pkg::OPC_COUNT) begin
          if (in_match[g * aoc_pkg::GRP_SIZE + j]) begin
            sum_next.hit[g]  = 1'b1;
            sum_next.lidx[g] = aoc_pkg::GRP_IDX_W'(j);
            sum_next.cyc[g]  = aoc_pkg::OPC_CYC[g * aoc_pkg::GRP_SIZE + j];
            sum_next.len[g]  = aoc_pkg::OPC_LEN[g * aoc_pkg::GRP_SIZE + j];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_sum <= sum_next;
    end
  end

endmodule

/* sv/aoc_select.sv */
module aoc_select (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  aoc_pkg::grp_sum_t  in_sum,
  output logic               out_valid,
  input  logic               out_ready,
  output aoc_pkg::cls_res_t  out_res
);

  aoc_pkg::cls_res_t res_next;

  assign in_ready = !out_valid || out_ready;

  // Highest hitting group wins; no hit means undefined opcode
  always_comb begin
    res_next.index   = aoc_pkg::OPC_UNDEFINED;
    res_next.defined = 1'b0;
    res_next.cyc     = '0;
    res_next.len     = '0;
    for (int g = 0; g < aoc_pkg::GRP_COUNT; g++) begin
      if (in_sum.hit[g]) begin
        res_next.index   = aoc_pkg::IDX_W'(g * aoc_pkg::GRP_SIZE)
                         | aoc_pkg::IDX_W'(in_sum.lidx[g]);
        res_next.defined = 1'b1;
        res_next.cyc     = in_sum.cyc[g];
        res_next.len     = in_sum.len[g];
      end
    end
  end

  // Output register: holds the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_res <= res_next;
    end
  end

endmodule

/* sv/avr_opcode_classifier.sv */
// AVR8 opcode classifier: each beat on s_* carries one 16-bit instruction word; each beat on
// m_* gives the list position of the matching opcode entry (latest entry wins on overlap),
// its cycle count and word length, or position 91 with zero numbers when nothing matches.
// A beat can be accepted every clock cycle unless a stall at m_* has filled the pipe.
// Each beat passes through input register, full opcode compare, per-group priority encode,
// and output select. Each stage holds on its own when the downstream side stalls, so bubbles
// inside the pipe still let new beats in while a result waits at the output.
module avr_opcode_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] instruction_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [6:0] instruction_index, [9:7] cycle_count,
                                 // [11:10] word_length, [15:12] zero
  output logic        m_tuser    // [0] is_defined
);

  logic                        match_valid;
  logic                        match_ready;
  logic [aoc_pkg::MATCH_W-1:0] match_vec;
  logic                        sum_valid;
  logic                        sum_ready;
  aoc_pkg::grp_sum_t           sum;
  aoc_pkg::cls_res_t           res;

  aoc_match u_match (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_word   (s_tdata),
    .out_valid (match_valid),
    .out_ready (match_ready),
    .out_match (match_vec)
  );

  aoc_prio u_prio (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (match_valid),
    .in_ready  (match_ready),
    .in_match  (match_vec),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_sum   (sum)
  );

  aoc_select u_select (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_sum    (sum),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  // Pack result beat
  assign m_tdata = {4'b0000, res.len, res.cyc, res.index};
  assign m_tuser = res.defined;

endmodule

/* sv/aoc_checker.sv */
`include "avr_opcode_classifier_defines.svh"

module aoc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser
);

  logic s_beat;
  assign s_beat = s_tvalid && s_tready && (s_tdata == s_tdata);

  // Stalled result beat holds
  `AOC_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // Undefined result carries the undefined position and zero numbers
  `AOC_ASSERT_NOW(a_undef, m_tvalid && !m_tuser, m_tdata[6:0] == aoc_pkg::OPC_UNDEFINED && m_tdata[11:7] == 5'd0)

  // Defined result has a real position and nonzero numbers
  `AOC_ASSERT_NOW(a_def, m_tvalid && m_tuser, m_tdata[6:0] < aoc_pkg::OPC_UNDEFINED && m_tdata[9:7] != 3'd0 && m_tdata[11:10] != 2'd0)

  // Pipe never blocks input while the sink takes beats
  `AOC_ASSERT_NOW(a_flow, m_tready || s_beat, s_tready || !m_tready)

endmodule

bind avr_opcode_classifier aoc_checker u_aoc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
